// ===== sv/ecsm_pkg.sv =====
// ----------------------------------------------------------------------------
// ecsm_pkg
// Types, constants and modular helper functions for the affine EC scalar
// multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ecsm_pkg;

  localparam int FIELD_WIDTH = 64;
  localparam int CNT_W       = $clog2(FIELD_WIDTH);
  localparam int IDX_W       = 8;

  typedef logic [FIELD_WIDTH-1:0] felem_t;
  typedef logic [63:0]            word_t;
  typedef logic [IDX_W-1:0]       cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_CURVE_A = cfg_idx_t'(0);
  localparam cfg_idx_t REG_MODULUS = cfg_idx_t'(1);

  typedef struct packed {
    word_t      point_x;
    word_t      point_y;
    logic       point_at_infinity;
    logic [63:0] scalar;
  } in_word_t;

  typedef struct packed {
    word_t result_x;
    word_t result_y;
    logic  result_at_infinity;
    logic  bad_input;
  } out_word_t;

  // a + b mod m, operands below m
  function automatic felem_t fadd(input felem_t a, input felem_t b, input felem_t m);
    logic [FIELD_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return felem_t'(s);
  endfunction

  // a - b mod m, operands below m
  function automatic felem_t fsub(input felem_t a, input felem_t b, input felem_t m);
    felem_t r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = a + (m - b);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ec_affine_scalar_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// ec_affine_scalar_multiply_unit
// Affine elliptic-curve scalar multiply, right-to-left double-and-add.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i / in_stall_o / in_word_i carries a base point
//                 and a signed scalar. in_stall_o is high while a word is
//                 being worked on.
//   out channel : out_valid_o / out_stall_i / out_word_o carries k*P, the
//                 infinity flag and the bad input flag. A stalled result
//                 holds in the output register; the sequencer waits for it.
//   cfg channel : cfg_valid_i / cfg_ready_o writes curve_a (index 0) or the
//                 modulus (index 1); ready is always high.
// Cost: every field multiply is a bit-serial shift-add pass over the
//   FIELD_WIDTH bits of one operand. Each point add or double costs one
//   inversion by Fermat exponentiation (up to 2*FIELD_WIDTH multiplies)
//   plus three or four more multiplies, so the run time of a word grows
//   with popcount(k)+log2|k|. The shared multiplier sets the run time.
//   Trivial cases skip the multiplier and go straight to the output.
// Reset: curve_a = 0, modulus = 3, no result pending, sequencer idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ec_affine_scalar_multiply_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire ecsm_pkg::in_word_t   in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output ecsm_pkg::out_word_t       out_word_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire ecsm_pkg::cfg_idx_t   cfg_index_i,
  input  wire ecsm_pkg::word_t      cfg_data_i
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_MUL  = 5'd1;
  localparam logic [4:0] ST_AMOD = 5'd2;
  localparam logic [4:0] ST_LOOP = 5'd3;
  localparam logic [4:0] ST_PA0  = 5'd4;
  localparam logic [4:0] ST_PAT1 = 5'd5;
  localparam logic [4:0] ST_PAT2 = 5'd6;
  localparam logic [4:0] ST_PAT3 = 5'd7;
  localparam logic [4:0] ST_INV1 = 5'd8;
  localparam logic [4:0] ST_INV2 = 5'd9;
  localparam logic [4:0] ST_INV3 = 5'd10;
  localparam logic [4:0] ST_INV4 = 5'd11;
  localparam logic [4:0] ST_LAM  = 5'd12;
  localparam logic [4:0] ST_LAM2 = 5'd13;
  localparam logic [4:0] ST_X1   = 5'd14;
  localparam logic [4:0] ST_X2   = 5'd15;
  localparam logic [4:0] ST_X3   = 5'd16;
  localparam logic [4:0] ST_Y1   = 5'd17;
  localparam logic [4:0] ST_OUT  = 5'd18;

  localparam ecsm_pkg::felem_t FeOne = ecsm_pkg::felem_t'(1);
  localparam ecsm_pkg::felem_t FeTwo = ecsm_pkg::felem_t'(2);
  localparam ecsm_pkg::word_t  FieldMask = ecsm_pkg::word_t'({ecsm_pkg::FIELD_WIDTH{1'b1}});

  logic [4:0] state_q, state_d, ret_q, ret_d;

  ecsm_pkg::felem_t curve_a_q, modulus_q, a_q, a_d;
  ecsm_pkg::felem_t rx_q, rx_d, ry_q, ry_d, qx_q, qx_d, qy_q, qy_d;
  logic rinf_q, rinf_d, qinf_q, qinf_d;
  logic [63:0] kk_q, kk_d;
  ecsm_pkg::felem_t ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  logic ainf_q, ainf_d, binf_q, binf_d, dst_r_q, dst_r_d;
  ecsm_pkg::felem_t num_q, num_d, ir_q, ir_d, ib_q, ib_d, e_q, e_d;
  ecsm_pkg::felem_t lam_q, lam_d, xr_q, xr_d;
  ecsm_pkg::felem_t ma_q, ma_d, mb_q, mb_d, acc_q, acc_d;
  logic [ecsm_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic bad_q, bad_d;
  logic out_valid_q, out_valid_d;
  ecsm_pkg::out_word_t out_q, out_d;

  logic in_acc;
  logic wr_en, wr_inf;
  ecsm_pkg::felem_t wr_x, wr_y, step1;
  logic [63:0] kneg;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign kneg        = 64'd0 - in_word_i.scalar;
  assign step1       = ecsm_pkg::fadd(acc_q, acc_q, modulus_q);

  // sequencer around the shared shift-add multiplier
  always_comb begin
    state_d = state_q; ret_d = ret_q; a_d = a_q;
    rx_d = rx_q; ry_d = ry_q; rinf_d = rinf_q;
    qx_d = qx_q; qy_d = qy_q; qinf_d = qinf_q; kk_d = kk_q;
    ax_d = ax_q; ay_d = ay_q; bx_d = bx_q; by_d = by_q;
    ainf_d = ainf_q; binf_d = binf_q; dst_r_d = dst_r_q;
    num_d = num_q; ir_d = ir_q; ib_d = ib_q; e_d = e_q;
    lam_d = lam_q; xr_d = xr_q;
    ma_d = ma_q; mb_d = mb_q; acc_d = acc_q; cnt_d = cnt_q;
    bad_d = bad_q; out_d = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    wr_en = 1'b0; wr_inf = 1'b0; wr_x = '0; wr_y = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rinf_d = 1'b1; rx_d = '0; ry_d = '0; bad_d = 1'b0;
          if ((modulus_q < ecsm_pkg::felem_t'(3)) ||
              (!in_word_i.point_at_infinity &&
               ((in_word_i.point_x >= ecsm_pkg::word_t'(modulus_q)) ||
                (in_word_i.point_y >= ecsm_pkg::word_t'(modulus_q))))) begin
            bad_d = 1'b1;
            state_d = ST_OUT;
          end else if ((in_word_i.scalar == 64'd0) || in_word_i.point_at_infinity) begin
            state_d = ST_OUT;
          end else begin
            qx_d = ecsm_pkg::felem_t'(in_word_i.point_x);
            qinf_d = 1'b0;
            if (in_word_i.scalar[63]) begin
              qy_d = (in_word_i.point_y == 64'd0) ? '0 :
                     modulus_q - ecsm_pkg::felem_t'(in_word_i.point_y);
              kk_d = kneg;
            end else begin
              qy_d = ecsm_pkg::felem_t'(in_word_i.point_y);
              kk_d = in_word_i.scalar;
            end
            // reduce curve_a by multiplying 1 * curve_a
            ma_d = FeOne; mb_d = curve_a_q; acc_d = '0; cnt_d = '0;
            ret_d = ST_AMOD; state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        acc_d = mb_q[ecsm_pkg::FIELD_WIDTH-1] ?
                ecsm_pkg::fadd(step1, ma_q, modulus_q) : step1;
        mb_d  = mb_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ecsm_pkg::CNT_W'(ecsm_pkg::FIELD_WIDTH - 1)) begin
          state_d = ret_q;
        end
      end
      ST_AMOD: begin
        a_d = acc_q;
        state_d = ST_LOOP;
      end
      ST_LOOP: begin
        if (kk_q == 64'd0) begin
          state_d = ST_OUT;
        end else if (kk_q[0]) begin
          ax_d = rx_q; ay_d = ry_q; ainf_d = rinf_q;
          bx_d = qx_q; by_d = qy_q; binf_d = qinf_q;
          dst_r_d = 1'b1; kk_d = {kk_q[63:1], 1'b0};
          state_d = ST_PA0;
        end else begin
          kk_d = kk_q >> 1;
          if ((kk_q >> 1) != 64'd0) begin
            ax_d = qx_q; ay_d = qy_q; ainf_d = qinf_q;
            bx_d = qx_q; by_d = qy_q; binf_d = qinf_q;
            dst_r_d = 1'b0;
            state_d = ST_PA0;
          end
        end
      end
      ST_PA0: begin
        if (ainf_q) begin
          wr_en = 1'b1; wr_x = bx_q; wr_y = by_q; wr_inf = binf_q;
          state_d = ST_LOOP;
        end else if (binf_q) begin
          wr_en = 1'b1; wr_x = ax_q; wr_y = ay_q; wr_inf = ainf_q;
          state_d = ST_LOOP;
        end else if ((ax_q == bx_q) &&
                     (ecsm_pkg::fadd(ay_q, by_q, modulus_q) == '0)) begin
          wr_en = 1'b1; wr_inf = 1'b1;
          state_d = ST_LOOP;
        end else if ((ax_q == bx_q) && (ay_q == by_q)) begin
          ma_d = ax_q; mb_d = ax_q; acc_d = '0; cnt_d = '0;
          ret_d = ST_PAT1; state_d = ST_MUL;
        end else begin
          num_d = ecsm_pkg::fsub(by_q, ay_q, modulus_q);
          ib_d = ecsm_pkg::fsub(bx_q, ax_q, modulus_q);
          ir_d = FeOne; e_d = modulus_q - FeTwo;
          state_d = ST_INV1;
        end
      end
      ST_PAT1: begin
        num_d = step1;
        state_d = ST_PAT2;
      end
      ST_PAT2: begin
        num_d = ecsm_pkg::fadd(num_q, acc_q, modulus_q);
        state_d = ST_PAT3;
      end
      ST_PAT3: begin
        num_d = ecsm_pkg::fadd(num_q, a_q, modulus_q);
        ib_d = ecsm_pkg::fadd(ay_q, ay_q, modulus_q);
        ir_d = FeOne; e_d = modulus_q - FeTwo;
        state_d = ST_INV1;
      end
      // Fermat inversion, exponent bits low to high
      ST_INV1: begin
        if (e_q[0]) begin
          ma_d = ir_q; mb_d = ib_q; acc_d = '0; cnt_d = '0;
          ret_d = ST_INV2; state_d = ST_MUL;
        end else begin
          state_d = ST_INV3;
        end
      end
      ST_INV2: begin
        ir_d = acc_q;
        state_d = ST_INV3;
      end
      ST_INV3: begin
        if ((e_q >> 1) == '0) begin
          state_d = ST_LAM;
        end else begin
          ma_d = ib_q; mb_d = ib_q; acc_d = '0; cnt_d = '0;
          ret_d = ST_INV4; state_d = ST_MUL;
        end
      end
      ST_INV4: begin
        ib_d = acc_q; e_d = e_q >> 1;
        state_d = ST_INV1;
      end
      ST_LAM: begin
        ma_d = num_q; mb_d = ir_q; acc_d = '0; cnt_d = '0;
        ret_d = ST_LAM2; state_d = ST_MUL;
      end
      ST_LAM2: begin
        lam_d = acc_q;
        ma_d = acc_q; mb_d = acc_q; acc_d = '0; cnt_d = '0;
        ret_d = ST_X1; state_d = ST_MUL;
      end
      ST_X1: begin
        xr_d = ecsm_pkg::fsub(acc_q, ax_q, modulus_q);
        state_d = ST_X2;
      end
      ST_X2: begin
        xr_d = ecsm_pkg::fsub(xr_q, bx_q, modulus_q);
        state_d = ST_X3;
      end
      ST_X3: begin
        ma_d = lam_q; mb_d = ecsm_pkg::fsub(ax_q, xr_q, modulus_q);
        acc_d = '0; cnt_d = '0;
        ret_d = ST_Y1; state_d = ST_MUL;
      end
      ST_Y1: begin
        wr_en = 1'b1; wr_x = xr_q;
        wr_y = ecsm_pkg::fsub(acc_q, ay_q, modulus_q);
        state_d = ST_LOOP;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.result_x = rinf_q ? '0 : ecsm_pkg::word_t'(rx_q);
          out_d.result_y = rinf_q ? '0 : ecsm_pkg::word_t'(ry_q);
          out_d.result_at_infinity = rinf_q;
          out_d.bad_input = bad_q;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // write back the point operation result
    if (wr_en) begin
      if (dst_r_q) begin
        rx_d = wr_x; ry_d = wr_y; rinf_d = wr_inf;
      end else begin
        qx_d = wr_x; qy_d = wr_y; qinf_d = wr_inf;
      end
    end
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      curve_a_q   <= '0;
      modulus_q   <= ecsm_pkg::felem_t'(3);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == ecsm_pkg::REG_CURVE_A) begin
          curve_a_q <= ecsm_pkg::felem_t'(cfg_data_i & FieldMask);
        end else if (cfg_index_i == ecsm_pkg::REG_MODULUS) begin
          modulus_q <= ecsm_pkg::felem_t'(cfg_data_i & FieldMask);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ret_q <= ret_d; a_q <= a_d;
    rx_q <= rx_d; ry_q <= ry_d; rinf_q <= rinf_d;
    qx_q <= qx_d; qy_q <= qy_d; qinf_q <= qinf_d; kk_q <= kk_d;
    ax_q <= ax_d; ay_q <= ay_d; bx_q <= bx_d; by_q <= by_d;
    ainf_q <= ainf_d; binf_q <= binf_d; dst_r_q <= dst_r_d;
    num_q <= num_d; ir_q <= ir_d; ib_q <= ib_d; e_q <= e_d;
    lam_q <= lam_d; xr_q <= xr_d;
    ma_q <= ma_d; mb_q <= mb_d; acc_q <= acc_d; cnt_q <= cnt_d;
    bad_q <= bad_d; out_q <= out_d;
  end

endmodule

`default_nettype wire

// ===== sv/ecsm_checker.sv =====
// ----------------------------------------------------------------------------
// ecsm_checker
// Port-level checks for the affine EC scalar multiply unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ecsm_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire ecsm_pkg::out_word_t out_word_o
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // infinity reads as zero coordinates
  a_inf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.result_at_infinity |->
      out_word_o.result_x == 64'd0 && out_word_o.result_y == 64'd0)
    else $error("infinite result with nonzero coordinates");

  // rejected input gives infinity
  a_bad_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.bad_input |-> out_word_o.result_at_infinity)
    else $error("bad input without infinity");

  // busy after accepting a word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted a word back to back");

endmodule

bind ec_affine_scalar_multiply_unit ecsm_checker u_ecsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire
